// ----- src/adll_pkg.sv -----
// Shared codes, widths and controller/datapath interface types for the array linked list.
package adll_pkg;

    localparam int OP_W     = 3;
    localparam int HANDLE_W = 7;
    localparam int VALUE_W  = 32;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic            load;
        logic            rd_handle;
        logic            rd_dump_first;
        logic            rd_dump_next;
        logic            wr_node;
        logic            link_splice;
        logic            unlink;
        logic            emit;
        logic [ST_W-1:0] status;
        logic            last;
        logic            with_handle;
        logic            with_data;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            handle_ok;
        logic            full;
        logic            empty;
        logic            rd_end;
    } t_stat;

endpackage

// ----- src/adll_ctrl.sv -----
// Sequencing state machine for the array linked list operations.
module adll_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  adll_pkg::t_stat i_stat,
    output adll_pkg::t_cmd  o_cmd
);
    import adll_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_WNODE  = 3'd3;
    localparam logic [2:0] S_WLINK  = 3'd4;
    localparam logic [2:0] S_DUMP   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_FULL;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_WNODE;
                        end
                    end
                    OP_REMOVE: begin
                        if (!i_stat.handle_ok) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_BAD_HANDLE;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.rd_handle = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                    OP_INS_BEFORE, OP_INS_AFTER: begin
                        if (!i_stat.handle_ok) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_BAD_HANDLE;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else if (i_stat.full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_FULL;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.rd_handle = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_EMPTY;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.rd_dump_first = 1'b1;
                            n_state             = S_DUMP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (i_stat.op == OP_REMOVE) begin
                    o_cmd.unlink = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_OK;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.wr_node = 1'b1;
                    n_state       = S_WLINK;
                end
            end
            S_WNODE: begin
                o_cmd.wr_node = 1'b1;
                n_state       = S_WLINK;
            end
            S_WLINK: begin
                o_cmd.link_splice = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.status      = ST_OK;
                o_cmd.last        = 1'b1;
                o_cmd.with_handle = 1'b1;
                n_state           = S_IDLE;
            end
            S_DUMP: begin
                o_cmd.emit      = 1'b1;
                o_cmd.status    = ST_OK;
                o_cmd.with_data = 1'b1;
                o_cmd.last      = i_stat.rd_end;
                if (i_stat.rd_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_dump_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/adll_dp.sv -----
// Datapath: link and value memories, sentinel links, alive bits and result registers.
module adll_dp #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [adll_pkg::OP_W-1:0]        i_operation,
    input  logic [adll_pkg::HANDLE_W-1:0]    i_handle,
    input  logic signed [adll_pkg::VALUE_W-1:0] i_value,
    input  adll_pkg::t_cmd                   i_cmd,
    output adll_pkg::t_stat                  o_stat,
    output logic                             o_valid,
    output logic [adll_pkg::ST_W-1:0]        o_status,
    output logic [adll_pkg::HANDLE_W-1:0]    o_new_handle,
    output logic signed [adll_pkg::VALUE_W-1:0] o_data_out,
    output logic                             o_last
);
    import adll_pkg::*;

    localparam int SW = $clog2(CAPACITY + 2);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [SW-1:0] HEAD = SW'(0);
    localparam logic [SW-1:0] TAIL = SW'(1);

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
        logic [SW-1:0] t;
        t = slot - SW'(2);
        return t[AW-1:0];
    endfunction

    logic [SW-1:0]         mem_l [CAPACITY];
    logic [SW-1:0]         mem_r [CAPACITY];
    logic [DATA_WIDTH-1:0] mem_v [CAPACITY];

    logic [OP_W-1:0]       r_op;
    logic [HANDLE_W-1:0]   r_handle;
    logic [DATA_WIDTH-1:0] r_value;
    logic [SW-1:0]         r_next;
    logic [CAPACITY-1:0]   r_alive;
    logic [SW-1:0]         r_head_right;
    logic [SW-1:0]         r_tail_left;
    logic [SW-1:0]         r_a;
    logic [SW-1:0]         r_b;
    logic [SW-1:0]         r_rd_l;
    logic [SW-1:0]         r_rd_r;
    logic [DATA_WIDTH-1:0] r_rd_v;

    logic                  r_valid;
    logic [ST_W-1:0]       r_status;
    logic [HANDLE_W-1:0]   r_new_handle;
    logic signed [VALUE_W-1:0] r_data;
    logic                  r_last;

    logic [63:0]           in64;
    logic [63:0]           rd64;
    logic [HANDLE_W-1:0]   h_m1;
    logic [AW-1:0]         h_addr;
    logic [SW-1:0]         h_slot;
    logic [SW-1:0]         new_slot;
    logic [AW-1:0]         new_addr;
    logic [HANDLE_W-1:0]   new_handle;
    logic [SW-1:0]         sp_a;
    logic [SW-1:0]         sp_b;
    logic                  lk_en;
    logic [SW-1:0]         lk_a;
    logic [SW-1:0]         lk_b;
    logic [SW-1:0]         lk_vr;
    logic [SW-1:0]         lk_vl;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  l_we;
    logic [AW-1:0]         l_wa;
    logic [SW-1:0]         l_wd;
    logic                  r_we;
    logic [AW-1:0]         r_wa;
    logic [SW-1:0]         r_wd;

    assign in64       = {32'h0, $unsigned(i_value)};
    assign rd64       = 64'(r_rd_v);
    assign h_m1       = r_handle - HANDLE_W'(1);
    assign h_addr     = h_m1[AW-1:0];
    assign h_slot     = SW'(r_handle) + SW'(1);
    assign new_slot   = r_next + SW'(2);
    assign new_addr   = r_next[AW-1:0];
    assign new_handle = HANDLE_W'(r_next) + HANDLE_W'(1);

    assign o_stat.op        = r_op;
    assign o_stat.handle_ok = (r_handle != '0) && (8'(r_handle) <= 8'(r_next))
                              && r_alive[h_addr];
    assign o_stat.full      = (r_next == SW'(CAPACITY));
    assign o_stat.empty     = (r_head_right == TAIL);
    assign o_stat.rd_end    = (r_rd_r == TAIL);

    // neighbors of a new node
    always_comb begin
        case (r_op)
            OP_PUSH_FRONT: begin
                sp_a = HEAD;
                sp_b = r_head_right;
            end
            OP_PUSH_BACK: begin
                sp_a = r_tail_left;
                sp_b = TAIL;
            end
            OP_INS_BEFORE: begin
                sp_a = r_rd_l;
                sp_b = h_slot;
            end
            default: begin
                sp_a = h_slot;
                sp_b = r_rd_r;
            end
        endcase
    end

    // R[a] <= vr, L[b] <= vl
    assign lk_en = i_cmd.link_splice | i_cmd.unlink;
    assign lk_a  = i_cmd.unlink ? r_rd_l : r_a;
    assign lk_b  = i_cmd.unlink ? r_rd_r : r_b;
    assign lk_vr = i_cmd.unlink ? r_rd_r : new_slot;
    assign lk_vl = i_cmd.unlink ? r_rd_l : new_slot;

    always_comb begin
        l_we = 1'b0;
        l_wa = new_addr;
        l_wd = sp_a;
        r_we = 1'b0;
        r_wa = new_addr;
        r_wd = sp_b;
        if (i_cmd.wr_node) begin
            l_we = 1'b1;
            r_we = 1'b1;
        end else if (lk_en) begin
            l_we = (lk_b != TAIL);
            l_wa = slot_addr(lk_b);
            l_wd = lk_vl;
            r_we = (lk_a != HEAD);
            r_wa = slot_addr(lk_a);
            r_wd = lk_vr;
        end
    end

    assign rd_en = i_cmd.rd_handle | i_cmd.rd_dump_first | i_cmd.rd_dump_next;

    always_comb begin
        if (i_cmd.rd_handle) begin
            rd_addr = h_addr;
        end else if (i_cmd.rd_dump_first) begin
            rd_addr = slot_addr(r_head_right);
        end else begin
            rd_addr = slot_addr(r_rd_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            mem_l[l_wa] <= l_wd;
        end
        if (rd_en) begin
            r_rd_l <= mem_l[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem_r[r_wa] <= r_wd;
        end
        if (rd_en) begin
            r_rd_r <= mem_r[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_node) begin
            mem_v[new_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_v <= mem_v[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_handle <= i_handle;
            r_value  <= in64[DATA_WIDTH-1:0];
        end
        if (i_cmd.wr_node) begin
            r_a <= sp_a;
            r_b <= sp_b;
        end
        if (i_cmd.emit) begin
            r_status     <= i_cmd.status;
            r_last       <= i_cmd.last;
            r_new_handle <= i_cmd.with_handle ? new_handle : '0;
            r_data       <= i_cmd.with_data ? rd64[VALUE_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= '0;
            r_alive      <= '0;
            r_head_right <= TAIL;
            r_tail_left  <= HEAD;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.link_splice) begin
                r_next            <= r_next + SW'(1);
                r_alive[new_addr] <= 1'b1;
            end
            if (i_cmd.unlink) begin
                r_alive[h_addr] <= 1'b0;
            end
            if (lk_en && lk_a == HEAD) begin
                r_head_right <= lk_vr;
            end
            if (lk_en && lk_b == TAIL) begin
                r_tail_left <= lk_vl;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_new_handle = r_new_handle;
    assign o_data_out   = r_data;
    assign o_last       = r_last;

endmodule

// ----- src/array_doubly_linked_list.sv -----
// Top level: doubly linked list in single-port arrays, controller plus datapath.
// An error or empty dump reports from the decode state, a remove from the read state and an insert
// from the link state; busy drops as the result is shown, so the next beat may start then.
// Dump: the first value follows the read of the head's successor, then one value per cycle off the registered reads.
// Results cannot be stalled. Synchronous active-low reset empties the list, restarts
// handles at 1 and needs no clearing pass.
module array_doubly_linked_list #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [adll_pkg::OP_W-1:0]           i_operation,
    input  logic [adll_pkg::HANDLE_W-1:0]       i_handle,
    input  logic signed [adll_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    output logic [adll_pkg::ST_W-1:0]           o_status,
    output logic [adll_pkg::HANDLE_W-1:0]       o_new_handle,
    output logic signed [adll_pkg::VALUE_W-1:0] o_data_out,
    output logic                                o_last
);
    import adll_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    adll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    adll_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_operation),
        .i_handle     (i_handle),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_new_handle (o_new_handle),
        .o_data_out   (o_data_out),
        .o_last       (o_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_new_handle == '0)
        else $error("error result not final or carries a handle");

    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("controller idle in the middle of a dump");

    a_splice_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.link_splice |-> !w_stat.full)
        else $error("node spliced into a full store");

endmodule

// ----- sim/tb_array_doubly_linked_list.sv -----
// Self-checking testbench for the array doubly linked list: command beats, list model, scoreboard.
`timescale 1ns / 1ps

import adll_pkg::*;

typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [HANDLE_W-1:0] new_handle;
    logic [VALUE_W-1:0]  data_out;
    logic                last;
} t_list_result;

class ListScoreboard #(int CAP = 64);
    localparam int SLOTS = CAP + 2;
    localparam int HEAD  = 0;
    localparam int TAIL  = 1;

    bit [VALUE_W-1:0]  node_val [CAP];
    bit                node_live[CAP];
    bit [HANDLE_W-1:0] lnk_l [SLOTS];
    bit [HANDLE_W-1:0] lnk_r [SLOTS];
    int unsigned       handles_used;

    t_list_result pending[$];
    int errors;
    int checked;
    int n_dump_vals;
    int n_full;
    int n_bad;
    int n_empty;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            lnk_l[i] = '0;
            lnk_r[i] = '0;
        end
        for (int i = 0; i < CAP; i++) begin
            node_val[i]  = '0;
            node_live[i] = 1'b0;
        end
        lnk_r[HEAD]  = HANDLE_W'(TAIL);
        lnk_l[TAIL]  = HANDLE_W'(HEAD);
        handles_used = 0;
        errors = 0;
        checked = 0;
        n_dump_vals = 0;
        n_full = 0;
        n_bad = 0;
        n_empty = 0;
    endfunction

    function void push_exp(logic [ST_W-1:0] st, int nh, logic [VALUE_W-1:0] d, bit lst);
        t_list_result r;
        r.status     = st;
        r.new_handle = nh[HANDLE_W-1:0];
        r.data_out   = d;
        r.last       = lst;
        pending.push_back(r);
    endfunction

    function bit handle_live(int h);
        return h >= 1 && h <= handles_used && node_live[h-1];
    endfunction

    function int splice(int a, int b, logic [VALUE_W-1:0] v);
        int h;
        int s;
        h = handles_used + 1;
        s = h + 1;
        node_val[h-1]  = v;
        node_live[h-1] = 1'b1;
        lnk_l[s] = HANDLE_W'(a);
        lnk_r[s] = HANDLE_W'(b);
        lnk_r[a] = HANDLE_W'(s);
        lnk_l[b] = HANDLE_W'(s);
        handles_used = h;
        return h;
    endfunction

    function int pick_live();
        int live[$];
        for (int h = 1; h <= handles_used; h++)
            if (node_live[h-1]) live.push_back(h);
        if (live.size() == 0) return 0;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function bit idle();
        return pending.size() == 0;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] hdl,
                             logic [VALUE_W-1:0] v);
        int h;
        int s;
        int a;
        int b;
        int cur;
        int nxt;
        int n;
        h = int'(hdl);
        s = h + 1;
        if (op == OP_DUMP) begin
            cur = int'(lnk_r[HEAD]);
            if (cur == TAIL) begin
                push_exp(ST_EMPTY, 0, '0, 1'b1);
            end else begin
                n = 0;
                while (cur != TAIL && n < CAP) begin
                    nxt = int'(lnk_r[cur]);
                    push_exp(ST_OK, 0, node_val[cur-2], nxt == TAIL || n + 1 == CAP);
                    n_dump_vals++;
                    n++;
                    cur = nxt;
                end
            end
        end else if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (handles_used >= CAP)
                push_exp(ST_FULL, 0, '0, 1'b1);
            else if (op == OP_PUSH_FRONT)
                push_exp(ST_OK, splice(HEAD, int'(lnk_r[HEAD]), v), '0, 1'b1);
            else
                push_exp(ST_OK, splice(int'(lnk_l[TAIL]), TAIL, v), '0, 1'b1);
        end else if (op == OP_REMOVE || op == OP_INS_BEFORE || op == OP_INS_AFTER) begin
            if (!handle_live(h)) begin
                push_exp(ST_BAD_HANDLE, 0, '0, 1'b1);
            end else if (op == OP_REMOVE) begin
                a = int'(lnk_l[s]);
                b = int'(lnk_r[s]);
                lnk_r[a] = HANDLE_W'(b);
                lnk_l[b] = HANDLE_W'(a);
                node_live[h-1] = 1'b0;
                push_exp(ST_OK, 0, '0, 1'b1);
            end else if (handles_used >= CAP) begin
                push_exp(ST_FULL, 0, '0, 1'b1);
            end else if (op == OP_INS_BEFORE) begin
                push_exp(ST_OK, splice(int'(lnk_l[s]), s, v), '0, 1'b1);
            end else begin
                push_exp(ST_OK, splice(s, int'(lnk_r[s]), v), '0, 1'b1);
            end
        end
    endfunction

    function void check_result(t_list_result got);
        t_list_result want;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: status %0d handle %0d data %h last %0b",
                     $time, got.status, got.new_handle, got.data_out, got.last);
            return;
        end
        want = pending.pop_front();
        checked++;
        case (want.status)
            ST_FULL:       n_full++;
            ST_BAD_HANDLE: n_bad++;
            ST_EMPTY:      n_empty++;
            default: begin
            end
        endcase
        if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected status %0d handle %0d data %h last %0b,",
                     $time, want.status, want.new_handle, want.data_out, want.last);
            $display("    got status %0d handle %0d data %h last %0b",
                     got.status, got.new_handle, got.data_out, got.last);
        end
    endfunction
endclass

module tb_array_doubly_linked_list;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int N_RANDOM    = 500;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           i_operation = '0;
    logic [HANDLE_W-1:0]       i_handle = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic [ST_W-1:0]           o_status;
    logic [HANDLE_W-1:0]       o_new_handle;
    logic signed [VALUE_W-1:0] o_data_out;
    logic                      o_last;

    ListScoreboard #(CAPACITY) sb;
    int n_beats = 0;
    int cycles = 0;
    bit no_idle = 1'b0;

    array_doubly_linked_list #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_handle    (i_handle),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_new_handle(o_new_handle),
        .o_data_out  (o_data_out),
        .o_last      (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_list_result got;
        if (i_rst_n && o_valid) begin
            got.status     = o_status;
            got.new_handle = o_new_handle;
            got.data_out   = o_data_out;
            got.last       = o_last;
            sb.check_result(got);
        end
    end

    // hold the beat until accepted (start high, busy low at the edge)
    task automatic drive_beat(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                              input logic [VALUE_W-1:0] v);
        start       <= 1'b1;
        i_operation <= op;
        i_handle    <= h;
        i_value     <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(op, h, v);
        n_beats++;
    endtask

    task automatic sender_gap();
        if (no_idle) return;
        while ($urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (!sb.idle()) @(posedge i_clk);
    endtask

    task automatic random_beat(output bit counted);
        int r;
        logic [OP_W-1:0] op;
        logic [HANDLE_W-1:0] h;
        r = $urandom_range(0, 99);
        h = HANDLE_W'($urandom_range(0, 127));
        counted = 1'b1;
        if (r < 12) begin
            op = OP_PUSH_FRONT;
        end else if (r < 24) begin
            op = OP_PUSH_BACK;
        end else if (r < 32) begin
            op = OP_INS_BEFORE;
            h  = HANDLE_W'(sb.pick_live());
        end else if (r < 40) begin
            op = OP_INS_AFTER;
            h  = HANDLE_W'(sb.pick_live());
        end else if (r < 60) begin
            op = OP_REMOVE;
            h  = HANDLE_W'(sb.pick_live());
        end else if (r < 78) begin
            op = OP_DUMP;
        end else if (r < 93) begin
            case ($urandom_range(0, 2))
                0:       op = OP_REMOVE;
                1:       op = OP_INS_BEFORE;
                default: op = OP_INS_AFTER;
            endcase
        end else begin
            op = $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;
            counted = 1'b0;
        end
        drive_beat(op, h, $urandom());
    endtask

    initial begin
        int sent;
        bit counted;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, bad handles, value extremes, reserved codes
        drive_beat(OP_DUMP,       7'd0,   32'h0);
        drive_beat(OP_REMOVE,     7'd0,   32'h0);
        drive_beat(OP_INS_BEFORE, 7'd1,   32'h1234_5678);
        drive_beat(OP_PUSH_FRONT, 7'd127, 32'h8000_0000);
        drive_beat(OP_PUSH_BACK,  7'd0,   32'h7FFF_FFFF);
        drive_beat(OP_INS_BEFORE, 7'd1,   32'h0);
        drive_beat(OP_INS_AFTER,  7'd2,   32'hFFFF_FFFF);
        drive_beat(OP_INS_AFTER,  7'd1,   32'h5555_5555);
        drive_beat(OP_INS_BEFORE, 7'd2,   32'hAAAA_AAAA);
        drive_beat(OP_DUMP,       7'd127, 32'hFFFF_FFFF);
        drive_beat(OP_RSVD6,      7'd127, 32'hFFFF_FFFF);
        drive_beat(OP_RSVD7,      7'd1,   32'h0);
        drive_beat(OP_REMOVE,     7'd1,   32'hFFFF_FFFF);
        drive_beat(OP_REMOVE,     7'd1,   32'h0);
        drive_beat(OP_INS_AFTER,  7'd1,   32'h0BAD_0BAD);
        drive_beat(OP_REMOVE,     7'd127, 32'h0);
        drive_beat(OP_REMOVE,     7'd64,  32'h0);
        drive_beat(OP_REMOVE,     7'd3,   32'h0);
        drive_beat(OP_DUMP,       7'd0,   32'h0);
        drain();
        drive_beat(OP_REMOVE,     7'd2,   32'h0);
        drive_beat(OP_REMOVE,     7'd4,   32'h0);
        drive_beat(OP_REMOVE,     7'd5,   32'h0);
        drive_beat(OP_REMOVE,     7'd6,   32'h0);
        drive_beat(OP_DUMP,       7'd0,   32'h0);

        sent = 0;
        while (sent < N_RANDOM) begin
            no_idle = (sent >= 200 && sent < 300);
            sender_gap();
            random_beat(counted);
            if (counted) sent++;
            if (sent == 350 && counted) drain();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (!sb.idle()) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d beats, %0d handles used, %0d results checked, %0d dump values",
                 n_beats, sb.handles_used, sb.checked, sb.n_dump_vals);
        $display("Error results: %0d store full, %0d bad handle, %0d empty dump",
                 sb.n_full, sb.n_bad, sb.n_empty);
        if (sb.errors == 0 && sb.idle()) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
